>>> rtl/core/properties_text_tokenizer_unit_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef PROPERTIES_TEXT_TOKENIZER_UNIT_DEFINES_SVH
`define PROPERTIES_TEXT_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ptt_pkg.sv
`timescale 1ns / 1ps

package ptt_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] token_kind;
        logic [7:0] token_byte;
    } t_out_item;

    typedef enum logic [7:0] {
        MODE_WS      = 8'b0000_0001,
        MODE_COMMENT = 8'b0000_0010,
        MODE_KEY     = 8'b0000_0100,
        MODE_KEY_ESC = 8'b0000_1000,
        MODE_KEY_WS  = 8'b0001_0000,
        MODE_VAL     = 8'b0010_0000,
        MODE_VAL_ESC = 8'b0100_0000,
        MODE_VAL_WS  = 8'b1000_0000
    } t_mode;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_PAIR  = 2'd2;

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_DEL    = 8'h7F;

endpackage

>>> rtl/core/properties_text_tokenizer_unit.sv
// Properties-text tokenizer.
// Input channel (i_in_valid / o_in_ready / i_in_data): one request per cycle
// while o_in_ready is high, either a text byte (cmd = text) or an end-of-text
// marker that flushes a pending pair. Output channel (o_out_valid /
// i_out_ready / o_out_data): zero or one result per request, tagged key byte,
// value byte or pair complete. An accepted request waits in the input
// register, then loads the result register, which drives o_out_valid. The input
// channel takes one request per cycle while the receiver keeps up; the next
// parse state is computed combinationally between the input register and the
// result register. Requests that produce no result never wait on the output side.
// When the receiver stalls, the result register holds; the input register
// still drains requests that yield nothing, and a request that yields a
// result waits there, which drops o_in_ready until the result is taken.
// Reset (i_rst_n low, synchronous) empties both registers, puts the parser in
// whitespace mode and clears the key-present flag.
`timescale 1ns / 1ps
`include "properties_text_tokenizer_unit_defines.svh"

module properties_text_tokenizer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ptt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ptt_pkg::t_out_item o_out_data
);

    logic               r_in_valid;
    ptt_pkg::t_in_item  r_in;
    ptt_pkg::t_mode     r_mode;
    ptt_pkg::t_mode     n_mode;
    logic               r_key_present;
    logic               n_key_present;
    logic               r_out_valid;
    ptt_pkg::t_out_item r_out;
    ptt_pkg::t_out_item n_out;
    logic               n_emit;
    logic               w_fire;
    logic [7:0]         w_c;
    logic               w_printable;
    logic               w_graphic;
    logic               w_sep;

    assign w_c         = r_in.data_byte;
    assign w_printable = (w_c inside {[ptt_pkg::CH_SPACE:ptt_pkg::CH_TILDE]});
    assign w_graphic   = (w_c inside {[ptt_pkg::CH_BANG:ptt_pkg::CH_TILDE]});
    assign w_sep       = (w_c == ptt_pkg::CH_EQ) || (w_c == ptt_pkg::CH_COLON);

    always_comb begin
        n_mode           = r_mode;
        n_key_present    = r_key_present;
        n_emit           = 1'b0;
        n_out.token_kind = ptt_pkg::KIND_KEY;
        n_out.token_byte = w_c;
        if (r_in.cmd == ptt_pkg::CMD_END) begin
            n_emit           = r_key_present;
            n_out.token_kind = ptt_pkg::KIND_PAIR;
            n_out.token_byte = '0;
            n_key_present    = 1'b0;
            n_mode           = ptt_pkg::MODE_WS;
        end else begin
            case (r_mode)
                ptt_pkg::MODE_WS: begin
                    if (w_c == ptt_pkg::CH_HASH || w_c == ptt_pkg::CH_BANG) begin
                        n_mode = ptt_pkg::MODE_COMMENT;
                    end else if (w_c inside {[ptt_pkg::CH_BANG:ptt_pkg::CH_DEL]}) begin
                        n_mode        = ptt_pkg::MODE_KEY;
                        n_key_present = 1'b1;
                        n_emit        = 1'b1;
                    end
                end
                ptt_pkg::MODE_COMMENT: begin
                    if (w_c == ptt_pkg::CH_LF) begin
                        n_mode = ptt_pkg::MODE_WS;
                    end
                end
                ptt_pkg::MODE_KEY: begin
                    if (w_c == ptt_pkg::CH_BSLASH) begin
                        n_mode = ptt_pkg::MODE_KEY_ESC;
                    end else if (w_c == ptt_pkg::CH_SPACE) begin
                        n_mode = ptt_pkg::MODE_KEY_WS;
                    end else if (w_sep) begin
                        n_mode = ptt_pkg::MODE_VAL_WS;
                    end else if (w_c == ptt_pkg::CH_LF) begin
                        n_emit           = r_key_present;
                        n_out.token_kind = ptt_pkg::KIND_PAIR;
                        n_out.token_byte = '0;
                        n_key_present    = 1'b0;
                        n_mode           = ptt_pkg::MODE_WS;
                    end else if (w_graphic) begin
                        n_key_present = 1'b1;
                        n_emit        = 1'b1;
                    end
                end
                ptt_pkg::MODE_KEY_ESC: begin
                    n_mode = ptt_pkg::MODE_KEY;
                    if (w_printable) begin
                        n_key_present = 1'b1;
                        n_emit        = 1'b1;
                    end
                end
                ptt_pkg::MODE_KEY_WS: begin
                    if (w_sep) begin
                        n_mode = ptt_pkg::MODE_VAL_WS;
                    end else if (w_graphic) begin
                        n_mode           = ptt_pkg::MODE_VAL;
                        n_emit           = 1'b1;
                        n_out.token_kind = ptt_pkg::KIND_VALUE;
                    end
                end
                ptt_pkg::MODE_VAL: begin
                    n_out.token_kind = ptt_pkg::KIND_VALUE;
                    if (w_c == ptt_pkg::CH_BSLASH) begin
                        n_mode = ptt_pkg::MODE_VAL_ESC;
                    end else if (w_c == ptt_pkg::CH_LF) begin
                        n_emit           = r_key_present;
                        n_out.token_kind = ptt_pkg::KIND_PAIR;
                        n_out.token_byte = '0;
                        n_key_present    = 1'b0;
                        n_mode           = ptt_pkg::MODE_WS;
                    end else if (w_printable) begin
                        n_emit = 1'b1;
                    end
                end
                ptt_pkg::MODE_VAL_ESC: begin
                    n_out.token_kind = ptt_pkg::KIND_VALUE;
                    if (w_c == ptt_pkg::CH_LF) begin
                        // line continuation
                        n_mode = ptt_pkg::MODE_VAL_WS;
                    end else begin
                        n_mode = ptt_pkg::MODE_VAL;
                        n_emit = w_printable;
                        if (w_c == ptt_pkg::CH_N) begin
                            n_out.token_byte = ptt_pkg::CH_LF;
                        end else if (w_c == ptt_pkg::CH_R) begin
                            n_out.token_byte = ptt_pkg::CH_CR;
                        end else if (w_c == ptt_pkg::CH_T) begin
                            n_out.token_byte = ptt_pkg::CH_TAB;
                        end
                    end
                end
                ptt_pkg::MODE_VAL_WS: begin
                    if (w_c == ptt_pkg::CH_BSLASH) begin
                        n_mode = ptt_pkg::MODE_VAL_ESC;
                    end else if (w_graphic) begin
                        n_mode           = ptt_pkg::MODE_VAL;
                        n_emit           = 1'b1;
                        n_out.token_kind = ptt_pkg::KIND_VALUE;
                    end
                end
                default: begin
                    n_mode = ptt_pkg::MODE_WS;
                end
            endcase
        end
    end

    // Advance the parse stage unless its result would overwrite a held one.
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready || !n_emit);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ptt_pkg::MODE_WS;
            r_key_present <= 1'b0;
        end else if (w_fire) begin
            r_mode        <= n_mode;
            r_key_present <= n_key_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PTT_ASSERT_NOW(a_pair_byte_zero, i_clk, i_rst_n,
        r_out_valid && r_out.token_kind == ptt_pkg::KIND_PAIR,
        r_out.token_byte == 8'h00, "pair-complete result carries a nonzero byte")
    `PTT_ASSERT_NEXT(a_pair_clears_key, i_clk, i_rst_n,
        w_fire && n_emit && n_out.token_kind == ptt_pkg::KIND_PAIR,
        !r_key_present, "key flag still set after pair complete")
    `PTT_ASSERT_NEXT(a_key_sets_flag, i_clk, i_rst_n,
        w_fire && n_emit && n_out.token_kind == ptt_pkg::KIND_KEY,
        r_key_present, "key byte sent without setting key flag")
    `PTT_ASSERT_NEXT(a_end_resets, i_clk, i_rst_n,
        w_fire && r_in.cmd == ptt_pkg::CMD_END,
        r_mode == ptt_pkg::MODE_WS && !r_key_present, "end of text did not reset parser")
    `PTT_ASSERT_NOW(a_pair_needs_key, i_clk, i_rst_n,
        w_fire && n_emit && n_out.token_kind == ptt_pkg::KIND_PAIR,
        r_key_present, "pair complete sent without a key")

endmodule
